// ----- rtl/core/rds_group_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RDS group decoder.
// ----------------------------------------------------------------------------
`ifndef RDS_GROUP_DECODER_MACROS_SVH
`define RDS_GROUP_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RDSG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication, sampled on clk, off during reset.
`define RDSG_ASSERT_TWO(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rdsg_pkg.sv -----
// ----------------------------------------------------------------------------
// rdsg_pkg
// Shared types and constants of the RDS group decoder.
// ----------------------------------------------------------------------------
package rdsg_pkg;

    localparam int TEXT_WORDS = 16;
    localparam int TEXT_IDX_W = 4;

    localparam logic [63:0] DASH_NAME  = 64'h2D2D_2D2D_2D2D_2D2D;
    localparam logic [63:0] SPACE_NAME = 64'h2020_2020_2020_2020;

    localparam logic [12:0] DAY_MINUTES = 13'd1440;

    localparam logic [3:0] GTYPE_NAME  = 4'd0;
    localparam logic [3:0] GTYPE_TEXT  = 4'd2;
    localparam logic [3:0] GTYPE_CLOCK = 4'd4;

    localparam logic CMD_GROUP = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [2:0] {
        KIND_CLEARED = 3'd0,
        KIND_NAME    = 3'd1,
        KIND_TEXT    = 3'd2,
        KIND_CLOCK   = 3'd3,
        KIND_IGNORED = 3'd4,
        KIND_READ    = 3'd5
    } kind_t;

    // One classified word as it sits in the queue.
    typedef struct packed {
        kind_t                  kind;
        logic [1:0]             seg;
        logic [15:0]            chars;
        logic                   text_ab;
        logic [TEXT_IDX_W-1:0]  idx;
        logic [31:0]            text_data;
        logic [10:0]            local_min;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- rtl/core/rdsg_front.sv -----
// ----------------------------------------------------------------------------
// rdsg_front
// Classifies an incoming word and works out the local time of clock groups.
// ----------------------------------------------------------------------------
module rdsg_front (
    input  logic            cmd,
    input  logic [15:0]     block_a,
    input  logic [15:0]     block_b,
    input  logic [15:0]     block_c,
    input  logic [15:0]     block_d,
    input  logic [3:0]      read_word,
    output rdsg_pkg::op_t   op
);
    import rdsg_pkg::*;

    logic [3:0]         gtype;
    logic               verb;
    logic [4:0]         utc_hr;
    logic [5:0]         utc_min;
    logic [4:0]         offs;
    logic [10:0]        base_min;
    logic [9:0]         offs_min;
    logic signed [12:0] raw_min;
    logic signed [12:0] norm_min;

    assign gtype   = block_b[15:12];
    assign verb    = block_b[11];
    assign utc_hr  = {block_c[0], block_d[15:12]};
    assign utc_min = block_d[11:6];
    assign offs    = block_d[4:0];

    assign base_min = {5'd0, utc_min} + 11'(utc_hr) * 11'd60;
    assign offs_min = 10'(offs) * 10'd30;

    // raw range is -930 .. 2853, so one correction lands in 0 .. 1439
    always_comb
    begin
        if (block_d[5])
            raw_min = $signed({2'b00, base_min}) - $signed({3'b000, offs_min});
        else
            raw_min = $signed({2'b00, base_min}) + $signed({3'b000, offs_min});

        if (raw_min < 0)
            norm_min = raw_min + $signed(DAY_MINUTES);
        else if (raw_min >= $signed(DAY_MINUTES))
            norm_min = raw_min - $signed(DAY_MINUTES);
        else
            norm_min = raw_min;
    end

    always_comb
    begin
        op.seg       = block_b[1:0];
        op.chars     = block_d;
        op.text_ab   = block_b[4];
        op.idx       = block_b[3:0];
        op.text_data = {block_c, block_d};
        op.local_min = norm_min[10:0];

        priority if (cmd != CMD_GROUP)
        begin
            op.kind = KIND_READ;
            op.idx  = read_word;
        end
        else if (block_a == 16'd0)
            op.kind = KIND_CLEARED;
        else if (gtype == GTYPE_NAME)
            op.kind = KIND_NAME;
        else if (gtype == GTYPE_TEXT && !verb)
            op.kind = KIND_TEXT;
        else if (gtype == GTYPE_CLOCK && !verb)
            op.kind = KIND_CLOCK;
        else
            op.kind = KIND_IGNORED;
    end

endmodule

// ----- rtl/core/rdsg_queue.sv -----
// ----------------------------------------------------------------------------
// rdsg_queue
// Two-entry queue between the classifier and the executing stage.
// ----------------------------------------------------------------------------
module rdsg_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rdsg_pkg::op_t           din,
    input  logic                    pop,
    output rdsg_pkg::op_t           dout,
    output rdsg_pkg::q_status_t     status
);
    import rdsg_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign dout         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

// ----- rtl/core/rdsg_back.sv -----
// ----------------------------------------------------------------------------
// rdsg_back
// Executes classified words against the name, text and time state and
// registers one result word per executed word.
// ----------------------------------------------------------------------------
module rdsg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  rdsg_pkg::op_t   op,
    input  logic            op_valid,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      group_kind,
    output logic [63:0]     station_name,
    output logic            name_changed,
    output logic [31:0]     text_word,
    output logic            text_cleared,
    output logic            time_changed,
    output logic [4:0]      hours,
    output logic [5:0]      minutes
);
    import rdsg_pkg::*;

    logic [63:0]            cand_reg, cand_next;
    logic [63:0]            conf_reg, conf_next;
    logic [63:0]            cur_reg, cur_next;
    logic [31:0]            text_data_reg [TEXT_WORDS];
    logic [TEXT_WORDS-1:0]  text_vld_reg, text_vld_next;
    logic                   ab_reg, ab_next;
    logic [4:0]             hours_reg, hours_next;
    logic [5:0]             minutes_reg, minutes_next;

    logic                   out_valid_reg, out_valid_next;
    kind_t                  kind_reg, kind_next;
    logic                   changed_reg, changed_next;
    logic [31:0]            word_reg, word_next;
    logic                   cleared_reg, cleared_next;
    logic                   tchanged_reg, tchanged_next;

    logic [5:0]             seg_lo;
    logic [21:0]            hr_prod;
    logic [4:0]             clk_hr;
    logic [5:0]             clk_min;

    assign pop = op_valid && (!out_valid_reg || !out_stall);

    // segment 0 holds the top two characters
    assign seg_lo = {~op.seg, 4'b0000};

    // minutes / 60 by reciprocal, exact for 0 .. 1439
    assign hr_prod = {11'd0, op.local_min} * 22'd1093;
    assign clk_hr  = hr_prod[20:16];
    assign clk_min = 6'(op.local_min - 11'(clk_hr) * 11'd60);

    always_comb
    begin
        cand_next      = cand_reg;
        conf_next      = conf_reg;
        cur_next       = cur_reg;
        text_vld_next  = text_vld_reg;
        ab_next        = ab_reg;
        hours_next     = hours_reg;
        minutes_next   = minutes_reg;

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        changed_next   = changed_reg;
        word_next      = word_reg;
        cleared_next   = cleared_reg;
        tchanged_next  = tchanged_reg;

        if (pop)
        begin
            out_valid_next = 1'b1;
            kind_next      = op.kind;
            changed_next   = 1'b0;
            word_next      = 32'd0;
            cleared_next   = 1'b0;
            tchanged_next  = 1'b0;

            unique case (op.kind)
                KIND_READ:
                begin
                    if (text_vld_reg[op.idx])
                        word_next = text_data_reg[op.idx];
                end
                KIND_CLEARED:
                begin
                    cand_next     = DASH_NAME;
                    conf_next     = DASH_NAME;
                    cur_next      = SPACE_NAME;
                    text_vld_next = '0;
                    cleared_next  = 1'b1;
                end
                KIND_NAME:
                begin
                    if (cand_reg[seg_lo +: 16] == op.chars)
                    begin
                        conf_next[seg_lo +: 16] = op.chars;
                        if (op.seg == 2'd3 && cand_reg == conf_next && conf_next != cur_reg)
                        begin
                            cur_next     = conf_next;
                            changed_next = 1'b1;
                        end
                    end
                    else
                        cand_next[seg_lo +: 16] = op.chars;
                end
                KIND_TEXT:
                begin
                    if (op.text_ab != ab_reg)
                    begin
                        ab_next       = op.text_ab;
                        text_vld_next = '0;
                        cleared_next  = 1'b1;
                    end
                    text_vld_next[op.idx] = 1'b1;
                    word_next             = op.text_data;
                end
                KIND_CLOCK:
                begin
                    if (clk_hr != hours_reg || clk_min != minutes_reg)
                    begin
                        hours_next    = clk_hr;
                        minutes_next  = clk_min;
                        tchanged_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg      <= DASH_NAME;
            conf_reg      <= DASH_NAME;
            cur_reg       <= SPACE_NAME;
            text_vld_reg  <= '0;
            ab_reg        <= 1'b0;
            hours_reg     <= 5'd0;
            minutes_reg   <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cand_reg      <= cand_next;
            conf_reg      <= conf_next;
            cur_reg       <= cur_next;
            text_vld_reg  <= text_vld_next;
            ab_reg        <= ab_next;
            hours_reg     <= hours_next;
            minutes_reg   <= minutes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        changed_reg  <= changed_next;
        word_reg     <= word_next;
        cleared_reg  <= cleared_next;
        tchanged_reg <= tchanged_next;
        if (pop && op.kind == KIND_TEXT)
            text_data_reg[op.idx] <= op.text_data;
    end

    // name and time state only move on pop, so they hold while stalled
    assign out_valid    = out_valid_reg;
    assign group_kind   = kind_reg;
    assign station_name = cur_reg;
    assign name_changed = changed_reg;
    assign text_word    = word_reg;
    assign text_cleared = cleared_reg;
    assign time_changed = tchanged_reg;
    assign hours        = hours_reg;
    assign minutes      = minutes_reg;

endmodule

// ----- rtl/core/rds_group_decoder.sv -----
// Accepted words are written to the queue, then executed into registered result words.
// Throughput: one word per cycle, retired by the executor while out_stall is low.
// A two-entry queue between classifier and executor absorbs output stalls.
// Reset: names go to dashes (candidate, confirmed) and spaces (published), the
// text store reads as zero, the A/B flag and local time go to 0, queue and output empty.
// ----------------------------------------------------------------------------
// rds_group_decoder
// Top level: classifier, queue and executor for RDS groups and text reads.
// ----------------------------------------------------------------------------
`include "rds_group_decoder_macros.svh"

module rds_group_decoder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            cmd,
    input  logic [15:0]     block_a,
    input  logic [15:0]     block_b,
    input  logic [15:0]     block_c,
    input  logic [15:0]     block_d,
    input  logic [3:0]      read_word,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [2:0]      group_kind,
    output logic [63:0]     station_name,
    output logic            name_changed,
    output logic [31:0]     text_word,
    output logic            text_cleared,
    output logic            time_changed,
    output logic [4:0]      hours,
    output logic [5:0]      minutes
);
    import rdsg_pkg::*;

    op_t        front_op;
    op_t        queued_op;
    q_status_t  q_status;
    logic       push;
    logic       pop;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    rdsg_front u_front (
        .cmd       (cmd),
        .block_a   (block_a),
        .block_b   (block_b),
        .block_c   (block_c),
        .block_d   (block_d),
        .read_word (read_word),
        .op        (front_op)
    );

    rdsg_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (front_op),
        .pop    (pop),
        .dout   (queued_op),
        .status (q_status)
    );

    rdsg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (queued_op),
        .op_valid     (!q_status.empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .group_kind   (group_kind),
        .station_name (station_name),
        .name_changed (name_changed),
        .text_word    (text_word),
        .text_cleared (text_cleared),
        .time_changed (time_changed),
        .hours        (hours),
        .minutes      (minutes)
    );

    `RDSG_ASSERT_IMP(a_name_kind, out_valid && name_changed, group_kind == KIND_NAME, "name change on non-name word")
    `RDSG_ASSERT_IMP(a_clear_kind, out_valid && text_cleared, group_kind == KIND_CLEARED || group_kind == KIND_TEXT, "text clear on wrong word kind")
    `RDSG_ASSERT_IMP(a_time_kind, out_valid && time_changed, group_kind == KIND_CLOCK && hours <= 5'd23 && minutes <= 6'd59, "bad time update")
    `RDSG_ASSERT_TWO(a_latency, push && q_status.empty && !out_valid, out_valid, "result missing two cycles after idle accept")

endmodule
